// ===== rtl/core/whbm_pkg.sv =====
// Shared types, codes and helpers for the windowed Hamming best-match block.
package whbm_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int IDX_W      = 10;
  localparam int WIDX_W     = 3;
  localparam int DATA_W     = 64;
  localparam int DESC_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int HALF_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;

  // Item kinds carried in tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DESC_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 2'd2;

  // Register values after reset.
  localparam logic [DESC_W-1:0]  DESC_BITS_RESET   = 10'd256;
  localparam logic [COUNT_W-1:0] TRAIN_COUNT_RESET = 11'd1;
  localparam logic [HALF_W-1:0]  WINDOW_HALF_RESET = 6'd10;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } whbm_state_t;

  // Commands from the controller to the datapath and top level.
  typedef struct packed {
    logic ready;
    logic start;
    logic step;
    logic finish;
  } whbm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query_end;
    logic window_empty;
    logic issue_last;
    logic pipe_busy;
  } whbm_stat_t;

  // Number of ones in one byte.
  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, b[i]};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/windowed_hamming_best_match.sv =====
// Top level: configuration registers, result register and the core instances.
// Load items and query words other than the last are taken one per cycle while idle.
// A query's last word starts a scan of N words, N being the candidates times the
// words per descriptor, one word XOR-counted per cycle through the single train RAM
// read port, then the pipeline drains; an empty window skips the scan. Either waits
// while the sink holds an earlier result; the next item is taken the cycle after it loads.
// Reset restores desc_bits 256, train_count 1, window_half 10; RAM and query buffer stay.
module windowed_hamming_best_match #(
  parameter int WORD_BITS     = 64,
  parameter int DESC_MAX_BITS = 512,
  parameter int MAX_DESCS     = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_axis_tdata: desc_index[9:0], word_index[12:10], word_data[76:13], zero pad
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [whbm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // s_axis_tuser: cmd[0]
  input  logic                                 s_axis_tuser,
  // m_axis_tdata: query_index[9:0], best_index[19:10], best_distance[29:20], zero pad
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [whbm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [whbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [whbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import whbm_pkg::*;

  localparam int WPD    = DESC_MAX_BITS / WORD_BITS;
  localparam int WI_W   = (WPD > 1) ? $clog2(WPD) : 1;
  localparam int DIST_W = $clog2(DESC_MAX_BITS + 1);

  // Effective descriptor length from a raw register value.
  function automatic logic [DIST_W-1:0] eff_of(input logic [DESC_W-1:0] v);
    logic [DIST_W-1:0] e;
    if (v == '0) begin
      e = DIST_W'(1);
    end else if (int'(v) > DESC_MAX_BITS) begin
      e = DIST_W'(DESC_MAX_BITS);
    end else begin
      e = DIST_W'(v);
    end
    return e;
  endfunction

  // Index of the last word holding valid bits.
  function automatic logic [WI_W-1:0] last_of(input logic [DIST_W-1:0] e);
    logic [WI_W-1:0] l;
    l = '0;
    for (int k = 1; k < WPD; k++) begin
      if (k * WORD_BITS < int'(e)) begin
        l = WI_W'(k);
      end
    end
    return l;
  endfunction

  // Mask of the valid bits in the last word.
  function automatic logic [WORD_BITS-1:0] mask_of(input logic [DIST_W-1:0] e,
                                                   input logic [WI_W-1:0] l);
    logic [WORD_BITS-1:0] m;
    int                   tail;
    tail = int'(e) - int'(l) * WORD_BITS;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = i < tail;
    end
    return m;
  endfunction

  // Configuration registers, with the descriptor length decoded at write time.
  logic [DIST_W-1:0]    eff_bits, wr_eff, rst_eff;
  logic [WI_W-1:0]      last_word, wr_last, rst_last;
  logic [WORD_BITS-1:0] tail_mask, wr_mask, rst_mask;
  logic [COUNT_W-1:0]   train_count;
  logic [HALF_W-1:0]    window_half;

  always_comb begin
    wr_eff   = eff_of(cfg_data[DESC_W-1:0]);
    wr_last  = last_of(wr_eff);
    wr_mask  = mask_of(wr_eff, wr_last);
    rst_eff  = eff_of(DESC_BITS_RESET);
    rst_last = last_of(rst_eff);
    rst_mask = mask_of(rst_eff, rst_last);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_bits    <= rst_eff;
      last_word   <= rst_last;
      tail_mask   <= rst_mask;
      train_count <= TRAIN_COUNT_RESET;
      window_half <= WINDOW_HALF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DESC_BITS: begin
          eff_bits  <= wr_eff;
          last_word <= wr_last;
          tail_mask <= wr_mask;
        end
        REG_TRAIN_COUNT: begin
          train_count <= cfg_data[COUNT_W-1:0];
        end
        REG_WINDOW_HALF: begin
          window_half <= cfg_data[HALF_W-1:0];
        end
        default: begin
          train_count <= train_count;
        end
      endcase
    end
  end

  // Controller and datapath.
  whbm_cmd_t        ccmd;
  whbm_stat_t       dstat;
  logic             in_accept;
  logic             out_free;
  logic [IDX_W-1:0] res_query_index, res_best_index, res_best_distance;

  assign s_axis_tready = ccmd.ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  whbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (dstat),
    .out_free (out_free),
    .cmd      (ccmd)
  );

  whbm_dp #(
    .WORD_BITS     (WORD_BITS),
    .DESC_MAX_BITS (DESC_MAX_BITS),
    .MAX_DESCS     (MAX_DESCS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .in_accept         (in_accept),
    .in_cmd            (s_axis_tuser),
    .in_desc_index     (s_axis_tdata[IDX_W-1:0]),
    .in_word_index     (s_axis_tdata[IDX_W +: WIDX_W]),
    .in_word_data      (s_axis_tdata[IDX_W+WIDX_W +: DATA_W]),
    .eff_bits          (eff_bits),
    .last_word         (last_word),
    .tail_mask         (tail_mask),
    .train_count       (train_count),
    .window_half       (window_half),
    .cmd               (ccmd),
    .stat              (dstat),
    .res_query_index   (res_query_index),
    .res_best_index    (res_best_index),
    .res_best_distance (res_best_distance)
  );

  // Result register: holds one item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ccmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ccmd.finish) begin
      m_axis_tdata <= {2'b00, res_best_distance, res_best_index, res_query_index};
    end
  end

  // No input item is taken while distance words are still in flight.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    dstat.pipe_busy |-> !s_axis_tready)
    else $error("input accepted while the distance pipeline is busy");

  // A result is handed off only when the result register can take it.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ccmd.finish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote an item not yet taken");

  // The reported distance never exceeds the starting distance.
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    ccmd.finish |=> (int'(m_axis_tdata[2*IDX_W +: IDX_W]) <= int'(eff_bits)))
    else $error("best distance above the descriptor length");

  // A scan step happens only while no item can be accepted.
  a_step_blocks: assert property (@(posedge clk) disable iff (rst)
    ccmd.step |-> (!s_axis_tready && !ccmd.finish))
    else $error("scan step overlaps input acceptance or handoff");

endmodule

// ===== rtl/core/whbm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module whbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/whbm_dp.sv =====
// Datapath: train store, query buffer, window bounds and the distance pipeline.
module whbm_dp #(
  parameter int WORD_BITS     = 64,
  parameter int DESC_MAX_BITS = 512,
  parameter int MAX_DESCS     = 1024
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_accept,
  input  logic                                         in_cmd,
  input  logic [whbm_pkg::IDX_W-1:0]                   in_desc_index,
  input  logic [whbm_pkg::WIDX_W-1:0]                  in_word_index,
  input  logic [whbm_pkg::DATA_W-1:0]                  in_word_data,
  input  logic [$clog2(DESC_MAX_BITS+1)-1:0]           eff_bits,
  input  logic [((DESC_MAX_BITS/WORD_BITS) > 1 ?
                 $clog2(DESC_MAX_BITS/WORD_BITS) : 1)-1:0] last_word,
  input  logic [WORD_BITS-1:0]                         tail_mask,
  input  logic [whbm_pkg::COUNT_W-1:0]                 train_count,
  input  logic [whbm_pkg::HALF_W-1:0]                  window_half,
  input  whbm_pkg::whbm_cmd_t                          cmd,
  output whbm_pkg::whbm_stat_t                         stat,
  output logic [whbm_pkg::IDX_W-1:0]                   res_query_index,
  output logic [whbm_pkg::IDX_W-1:0]                   res_best_index,
  output logic [whbm_pkg::IDX_W-1:0]                   res_best_distance
);

  import whbm_pkg::*;

  localparam int WPD     = DESC_MAX_BITS / WORD_BITS;
  localparam int WI_W    = (WPD > 1) ? $clog2(WPD) : 1;
  localparam int SLOT_W  = $clog2(MAX_DESCS);
  localparam int DIST_W  = $clog2(DESC_MAX_BITS + 1);
  localparam int CHUNKS  = (WORD_BITS + 7) / 8;
  localparam int PAD_W   = CHUNKS * 8;
  localparam int WSUM_W  = $clog2(WORD_BITS + 1);
  localparam int WIN_W   = 15;
  localparam int RAM_AW  = SLOT_W + WI_W;
  localparam int RAM_DEPTH = MAX_DESCS * (2 ** WI_W);

  localparam logic signed [WIN_W-1:0] ZERO_S = '0;
  localparam logic signed [WIN_W-1:0] ONE_S  = WIN_W'(1);
  localparam logic signed [WIN_W-1:0] MAX_S  = WIN_W'(MAX_DESCS);

  // Query buffer, written by query items, read one word per step.
  logic [WORD_BITS-1:0] qbuf [WPD];
  logic                 wi_ok;

  assign wi_ok = int'(in_word_index) < WPD;

  always_ff @(posedge clk) begin
    if (in_accept && in_cmd == CMD_QUERY && wi_ok) begin
      qbuf[WI_W'(in_word_index)] <= in_word_data[WORD_BITS-1:0];
    end
  end

  // Train store write on load items within range.
  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign ram_we    = in_accept && in_cmd == CMD_LOAD && wi_ok &&
                     int'(in_desc_index) < MAX_DESCS;
  assign ram_waddr = {SLOT_W'(in_desc_index), WI_W'(in_word_index)};

  // Candidate window around the query index, clipped to the loaded range.
  logic signed [WIN_W-1:0] idx_s, wh_s, cnt_s, lo_s, hi_s, lo_c, hi_c;

  always_comb begin
    idx_s = $signed(WIN_W'(in_desc_index));
    wh_s  = $signed(WIN_W'(window_half));
    if (int'(train_count) > MAX_DESCS) begin
      cnt_s = MAX_S;
    end else begin
      cnt_s = $signed(WIN_W'(train_count));
    end
    lo_s = idx_s - wh_s;
    hi_s = idx_s + wh_s - ONE_S;
    lo_c = (lo_s < ZERO_S) ? ZERO_S : lo_s;
    hi_c = (hi_s > cnt_s - ONE_S) ? cnt_s - ONE_S : hi_s;
  end

  assign stat.query_end    = in_cmd == CMD_QUERY && wi_ok &&
                             WI_W'(in_word_index) == last_word;
  assign stat.window_empty = lo_c > hi_c;

  // Address sequencer over candidates and their words.
  logic [SLOT_W-1:0] j, hi_r;
  logic [WI_W-1:0]   w;
  logic [IDX_W-1:0]  qidx;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      j    <= SLOT_W'(lo_c);
      hi_r <= SLOT_W'(hi_c);
      w    <= '0;
      qidx <= in_desc_index;
    end else if (cmd.step) begin
      if (w == last_word) begin
        w <= '0;
        j <= j + SLOT_W'(1);
      end else begin
        w <= w + WI_W'(1);
      end
    end
  end

  assign ram_raddr       = {j, w};
  assign stat.issue_last = (j == hi_r) && (w == last_word);

  whbm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_train_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word_data[WORD_BITS-1:0]),
    .re    (cmd.step),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage 1: query word and tags travel beside the RAM read.
  logic                 v1, first1, last1;
  logic [SLOT_W-1:0]    j1;
  logic [WORD_BITS-1:0] q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      q1     <= qbuf[w];
      first1 <= (w == '0);
      last1  <= (w == last_word);
      j1     <= j;
    end
  end

  // Masked difference word and per-byte counts.
  logic [WORD_BITS-1:0] diff;
  logic [PAD_W-1:0]     diff_pad;

  assign diff     = (ram_rdata ^ q1) & (last1 ? tail_mask : {WORD_BITS{1'b1}});
  assign diff_pad = PAD_W'(diff);

  logic              v2, first2, last2;
  logic [SLOT_W-1:0] j2;
  logic [3:0]        cnt2 [CHUNKS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      for (int k = 0; k < CHUNKS; k++) begin
        cnt2[k] <= popcount8(diff_pad[k*8 +: 8]);
      end
      first2 <= first1;
      last2  <= last1;
      j2     <= j1;
    end
  end

  // Stage 2: word count, running distance and best candidate.
  logic [WSUM_W-1:0] wsum;
  logic [DIST_W-1:0] dist_sum, acc, best_dist;
  logic [SLOT_W-1:0] best_idx;

  always_comb begin
    wsum = '0;
    for (int k = 0; k < CHUNKS; k++) begin
      wsum = wsum + WSUM_W'(cnt2[k]);
    end
    dist_sum = first2 ? DIST_W'(wsum) : acc + DIST_W'(wsum);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_dist <= eff_bits;
      best_idx  <= '0;
    end else if (v2) begin
      acc <= dist_sum;
      if (last2 && dist_sum < best_dist) begin
        best_dist <= dist_sum;
        best_idx  <= j2;
      end
    end
  end

  assign stat.pipe_busy = v1 || v2;

  assign res_query_index   = qidx;
  assign res_best_index    = IDX_W'(best_idx);
  assign res_best_distance = IDX_W'(best_dist);

endmodule

// ===== rtl/core/whbm_ctrl.sv =====
// Controller: sequences the candidate scan and hands off the result.
module whbm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  whbm_pkg::whbm_stat_t stat,
  input  logic                 out_free,
  output whbm_pkg::whbm_cmd_t  cmd
);

  import whbm_pkg::*;

  whbm_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && stat.query_end) begin
          state_next = stat.window_empty ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (stat.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        cmd.start = in_valid && stat.query_end;
      end
      ST_ISSUE: begin
        cmd.step = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DONE: begin
        cmd.finish = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== bench/windowed_hamming_best_match_tb.sv =====
// Self-checking testbench for the windowed Hamming best-match block.
`timescale 1ns / 100ps

module windowed_hamming_best_match_tb;
  import whbm_pkg::*;

  localparam int WORDS_PER_DESC = 8;
  localparam int MAX_BITS       = 512;
  localparam int MAX_SLOTS      = 1024;
  localparam int ITEM_TARGET    = 1150;
  localparam int LONG_HOLD      = 600;
  localparam int SETTLE_CYCLES  = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One result as it sits in m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [IDX_W-1:0] best_distance;
    logic [IDX_W-1:0] best_index;
    logic [IDX_W-1:0] query_index;
  } match_t;

  // Predicts each best match and checks results against them in order.
  class match_predictor;
    logic [DATA_W-1:0] train_words [MAX_SLOTS*WORDS_PER_DESC];
    logic [DATA_W-1:0] query_words [WORDS_PER_DESC];
    logic [DESC_W-1:0] desc_bits;
    logic [COUNT_W-1:0] train_count;
    logic [HALF_W-1:0] window_half;
    match_t pending_matches[$];
    int mismatches;

    function new();
      desc_bits   = DESC_BITS_RESET;
      train_count = TRAIN_COUNT_RESET;
      window_half = WINDOW_HALF_RESET;
      mismatches  = 0;
    endfunction

    function int pending();
      return pending_matches.size();
    endfunction

    // Descriptor length with out-of-range settings pulled into 1..MAX_BITS.
    function int used_bits();
      int b;
      b = int'(desc_bits);
      if (b < 1) b = 1;
      if (b > MAX_BITS) b = MAX_BITS;
      return b;
    endfunction

    // Candidate slots around a query index, clipped to the loaded range.
    function void window_of(input int qidx, output int lo, output int hi);
      int count;
      count = (int'(train_count) > MAX_SLOTS) ? MAX_SLOTS : int'(train_count);
      lo = qidx - int'(window_half);
      hi = qidx + int'(window_half) - 1;
      if (lo < 0) lo = 0;
      if (hi > count - 1) hi = count - 1;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_DESC_BITS:   desc_bits = value[DESC_W-1:0];
        REG_TRAIN_COUNT: train_count = value[COUNT_W-1:0];
        REG_WINDOW_HALF: window_half = value[HALF_W-1:0];
        default: ;
      endcase
    endfunction

    // Hamming distance between the query buffer and one train slot.
    function int distance_to(input int slot, input int bits);
      int d, remaining, take;
      logic [DATA_W-1:0] mask;
      d = 0;
      remaining = bits;
      for (int w = 0; w < WORDS_PER_DESC && remaining > 0; w++) begin
        take = (remaining < DATA_W) ? remaining : DATA_W;
        mask = (take == DATA_W) ? '1 : ((64'd1 << take) - 64'd1);
        d += $countones((query_words[w] ^ train_words[slot*WORDS_PER_DESC + w]) & mask);
        remaining -= take;
      end
      return d;
    endfunction

    // Apply one accepted item; a query's last word yields an expected match.
    function void take_item(input logic cmd, input logic [IDX_W-1:0] idx,
                            input logic [WIDX_W-1:0] wi, input logic [DATA_W-1:0] data);
      int bits, lo, hi, d, best, best_dist;
      match_t m;
      if (cmd == CMD_LOAD) begin
        train_words[int'(idx)*WORDS_PER_DESC + int'(wi)] = data;
        return;
      end
      query_words[wi] = data;
      bits = used_bits();
      if (int'(wi) != (bits - 1) / DATA_W) return;
      window_of(int'(idx), lo, hi);
      best = 0;
      best_dist = bits;
      for (int j = lo; j <= hi; j++) begin
        d = distance_to(j, bits);
        if (d < best_dist) begin
          best_dist = d;
          best = j;
        end
      end
      m.query_index   = idx;
      m.best_index    = best[IDX_W-1:0];
      m.best_distance = best_dist[IDX_W-1:0];
      pending_matches = {pending_matches, m};
    endfunction

    function void check_match(input logic [OUT_TDATA_W-1:0] tdata);
      match_t got, want;
      got = tdata[3*IDX_W-1:0];
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: unexpected result query %0d best %0d distance %0d",
                   got.query_index, got.best_index, got.best_distance);
        return;
      end
      want = pending_matches.pop_front();
      if (got.query_index !== want.query_index || got.best_index !== want.best_index ||
          got.best_distance !== want.best_distance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: query %0d best %0d distance %0d, expected %0d %0d %0d",
                   got.query_index, got.best_index, got.best_distance,
                   want.query_index, want.best_index, want.best_distance);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  match_predictor sb;
  int items_sent;
  bit calm;
  bit hold_request;
  bit [WORDS_PER_DESC-1:0] loaded [MAX_SLOTS];
  bit [WORDS_PER_DESC-1:0] query_seen;
  logic [DATA_W-1:0] base_words [3][WORDS_PER_DESC];

  windowed_hamming_best_match dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Observe every handshake at the clock edge; results first, then new work.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_match(m_axis_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.take_item(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[12:10],
                     s_axis_tdata[76:13]);
    end
  end

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Mostly near copies of a few base patterns, so distances are small and ties common.
  function automatic logic [DATA_W-1:0] pick_word(input int word);
    logic [DATA_W-1:0] flips;
    flips = 64'd1 << $urandom_range(0, 63);
    if ($urandom_range(0, 1) == 1) flips = flips | (64'd1 << $urandom_range(0, 63));
    if ($urandom_range(0, 3) == 0) flips = '0;
    case ($urandom_range(0, 9))
      0, 1: return {$urandom, $urandom};
      2: return '0;
      3: return '1;
      default: return base_words[$urandom_range(0, 2)][word] ^ flips;
    endcase
  endfunction

  task automatic send_item(input logic cmd, input int slot, input int word,
                           input logic [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'd0, data, WIDX_W'(word), IDX_W'(slot)};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (cmd == CMD_LOAD) loaded[slot][word] = 1'b1;
    else query_seen[word] = 1'b1;
  endtask

  // Load any candidate word not yet written, then send the query words.
  // A broken query skips or scrambles the words below the last one.
  task automatic run_query(input int qidx, input bit broken);
    int lo, hi, last;
    last = (sb.used_bits() - 1) / DATA_W;
    sb.window_of(qidx, lo, hi);
    for (int j = lo; j <= hi; j++)
      for (int k = 0; k <= last; k++)
        if (!loaded[j][k]) send_item(CMD_LOAD, j, k, pick_word(k));
    for (int k = 0; k < last; k++)
      if (!broken || !query_seen[k] || $urandom_range(0, 1) == 1)
        send_item(CMD_QUERY, broken ? $urandom_range(0, 1023) : qidx, k, pick_word(k));
    if (last < WORDS_PER_DESC - 1 && $urandom_range(0, 5) == 0)
      send_item(CMD_QUERY, qidx, $urandom_range(last + 1, WORDS_PER_DESC - 1),
                pick_word(WORDS_PER_DESC - 1));
    send_item(CMD_QUERY, qidx, last, pick_word(last));
  endtask

  // Stop offering items and wait until the block has delivered everything.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: random stalls per item, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Hang guard.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int ops, r, span, count, phase, wait_cycles;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_LOAD;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DESC_BITS;
    cfg_data = '0;
    items_sent = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    query_seen = '0;
    foreach (loaded[i]) loaded[i] = '0;
    foreach (base_words[p, w]) base_words[p][w] = {$urandom, $urandom};
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a single candidate, then a window above the loaded range.
    run_query(0, 0);
    run_query(1023, 0);
    // Extreme data values, top slot and word, and a query word past the last.
    send_item(CMD_LOAD, 1023, 7, '1);
    send_item(CMD_LOAD, 0, 7, '0);
    send_item(CMD_QUERY, 1023, 7, '1);

    // Zero length acts as one bit; zero train count leaves no candidates.
    settle();
    write_reg(REG_DESC_BITS, 0);
    write_reg(REG_TRAIN_COUNT, 0);
    run_query(3, 0);

    // Oversized length and count are clipped; a zero half width is empty.
    settle();
    write_reg(REG_DESC_BITS, 1023);
    write_reg(REG_TRAIN_COUNT, 2047);
    write_reg(REG_WINDOW_HALF, 0);
    run_query(500, 0);

    // Spare register index, widest window clipped at both ends, broken query.
    settle();
    write_reg(REG_SPARE, 2047);
    write_reg(REG_DESC_BITS, 64);
    write_reg(REG_TRAIN_COUNT, 3);
    write_reg(REG_WINDOW_HALF, 63);
    run_query(1, 1);
    settle();
    write_reg(REG_WINDOW_HALF, 1);

    // Random phases, each under its own settings; the long hold-off phase always runs.
    phase = 0;
    while (items_sent < ITEM_TARGET || phase < 3) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 9);
        if (r < 7) write_reg(REG_DESC_BITS, $urandom_range(1, 128));
        else if (r < 9) write_reg(REG_DESC_BITS, $urandom_range(129, 512));
        else write_reg(REG_DESC_BITS, ($urandom_range(0, 1) == 1) ? 512 : $urandom_range(0, 1023));
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 9);
        if (r < 7) write_reg(REG_TRAIN_COUNT, $urandom_range(1, 48));
        else if (r < 9) write_reg(REG_TRAIN_COUNT, $urandom_range(49, 1024));
        else write_reg(REG_TRAIN_COUNT, ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1024, 2047));
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 9);
        if (r < 7) write_reg(REG_WINDOW_HALF, $urandom_range(1, 6));
        else if (r < 9) write_reg(REG_WINDOW_HALF, $urandom_range(7, 32));
        else write_reg(REG_WINDOW_HALF, ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(32, 63));
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom_range(0, 2047));

      // The sink holds off once while a burst of queries piles up behind it.
      if (phase == 2) begin
        hold_request = 1'b1;
        calm = 1'b1;
      end

      // Query indexes mostly fall where the window meets loaded slots.
      count = (int'(sb.train_count) > MAX_SLOTS) ? MAX_SLOTS : int'(sb.train_count);
      span = count + int'(sb.window_half);
      if (span > 90) span = 90;
      ops = $urandom_range(10, 40);
      repeat (ops) begin
        r = $urandom_range(0, 9);
        if (r < 8)
          run_query(($urandom_range(0, 11) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, span),
                    r == 7);
        else if (r == 8 && sb.used_bits() <= MAX_BITS - DATA_W)
          send_item(CMD_QUERY, $urandom_range(0, 1023),
                    $urandom_range((sb.used_bits() - 1) / DATA_W + 1, WORDS_PER_DESC - 1),
                    pick_word(WORDS_PER_DESC - 1));
        else
          send_item(CMD_LOAD, $urandom_range(0, 1023), $urandom_range(0, 7),
                    pick_word($urandom_range(0, 7)));
      end
      phase++;
    end

    // Drain with a bound, then report.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (sb.pending() != 0) $display("MISMATCH: %0d results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
